// ----- rtl/infix_to_postfix_converter_macros.svh -----
// assertion macros for the infix to postfix converter
`ifndef INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH

// same-cycle implication, checked out of reset
`define ITP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itp assertion failed");

// next-cycle implication, checked out of reset
`define ITP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itp assertion failed");

`endif

// ----- rtl/itp_pkg.sv -----
// shared types, constants and helper functions of the infix to postfix converter
`timescale 1ns / 1ps

package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] SYM_PLUS   = 8'h2B;
    localparam logic [7:0] SYM_MINUS  = 8'h2D;
    localparam logic [7:0] SYM_MUL    = 8'h2A;
    localparam logic [7:0] SYM_DIV    = 8'h2F;
    localparam logic [7:0] SYM_POW    = 8'h5E;
    localparam logic [7:0] SYM_LPAREN = 8'h28;
    localparam logic [7:0] SYM_RPAREN = 8'h29;
    localparam logic [7:0] SYM_HASH   = 8'h23;
    localparam logic [7:0] SYM_NUL    = 8'h00;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
    localparam logic [1:0] ERR_UNMATCHED = 2'd2;

    localparam logic [2:0] PREC_LOW = 3'd1;
    localparam logic [2:0] PREC_ADD = 3'd2;
    localparam logic [2:0] PREC_MUL = 3'd3;
    localparam logic [2:0] PREC_POW = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WORK,
        ST_FLUSH
    } state_t;

    // command broadcast to every cell of the stack
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] din;
    } stack_cmd_t;

    function automatic logic is_op(input logic [7:0] c);
        logic r;
        case (c)
            SYM_PLUS, SYM_MINUS, SYM_MUL, SYM_DIV,
            SYM_POW, SYM_LPAREN, SYM_RPAREN, SYM_HASH: r = 1'b1;
            default:                                  r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] prec_of(input logic [7:0] c);
        logic [2:0] p;
        case (c)
            SYM_POW:           p = PREC_POW;
            SYM_MUL, SYM_DIV:  p = PREC_MUL;
            SYM_PLUS, SYM_MINUS: p = PREC_ADD;
            default:           p = PREC_LOW;
        endcase
        return p;
    endfunction

endpackage

// ----- rtl/itp_cell.sv -----
// one stack entry: takes its upper or lower neighbour's symbol on push or pop
`timescale 1ns / 1ps

module itp_cell
    import itp_pkg::*;
(
    input  logic       clk,
    input  stack_cmd_t cmd,
    input  logic [7:0] from_above,
    input  logic [7:0] from_below,
    output logic [7:0] sym
);

    logic [7:0] sym_reg;
    logic [7:0] sym_next;

    always_comb
    begin
        sym_next = sym_reg;
        if (cmd.push)
        begin
            sym_next = from_above;
        end
        else if (cmd.pop)
        begin
            sym_next = from_below;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg <= sym_next;
    end

    assign sym = sym_reg;

endmodule

// ----- rtl/itp_stack.sv -----
// operator stack built as a row of shifting cells, top of stack in cell 0
`timescale 1ns / 1ps

module itp_stack
    import itp_pkg::*;
(
    input  logic       clk,
    input  stack_cmd_t cmd,
    output logic [7:0] top
);

    logic [7:0] cell_sym [STACK_DEPTH];

    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        logic [7:0] above;
        logic [7:0] below;

        if (i == 0)
        begin : g_first
            assign above = cmd.din;
        end
        else
        begin : g_mid_up
            assign above = cell_sym[i-1];
        end

        if (i == STACK_DEPTH - 1)
        begin : g_last
            assign below = cell_sym[i];
        end
        else
        begin : g_mid_down
            assign below = cell_sym[i+1];
        end

        itp_cell u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .from_above (above),
            .from_below (below),
            .sym        (cell_sym[i])
        );
    end

    assign top = cell_sym[0];

endmodule

// ----- rtl/infix_to_postfix_converter.sv -----
// top level: shunting-yard infix to postfix converter over a shifting cell stack
// flow: an operand item is captured in cur_sym_reg on accept and is then registered into
//   out_sym_reg once the output slot is free; a new item is taken only in idle, after the
//   last one is done; the cell stack does a single pop per cycle, and a pop that emits
//   waits for a free output slot; an end item flushes every entry, then the terminator
// reset: state, fill count, error and output valid clear at once; stack cells keep
//   no reset and are only read below the fill count, so no clearing pass is needed
`timescale 1ns / 1ps

`include "infix_to_postfix_converter_macros.svh"

module infix_to_postfix_converter
    import itp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // input items
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_symbol
    input  logic       s_axis_tlast,   // end_of_expr
    // output items
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_symbol
    output logic       m_axis_tlast,   // last
    output logic [1:0] m_axis_tuser    // [1:0] status
);

    // control registers
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       err_reg, err_next;
    logic             out_valid_reg;

    // captured item and output payload
    logic [7:0] cur_sym_reg;
    logic       cur_eoe_reg;
    logic [7:0] out_sym_reg;
    logic       out_last_reg;
    logic [1:0] out_status_reg;

    // per-cycle decisions
    stack_cmd_t cmd;
    logic [7:0] top;
    logic       in_accept;
    logic       out_free;
    logic       emit;
    logic [7:0] emit_sym;
    logic       emit_last;
    logic       step_done;
    logic       flush_done;
    logic       stack_empty;
    logic       stack_full;

    itp_stack u_stack (
        .clk (clk),
        .cmd (cmd),
        .top (top)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    // output slot is free when empty or being drained this cycle
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign stack_empty   = (cnt_reg == '0);
    assign stack_full    = (cnt_reg >= CNT_W'(STACK_DEPTH));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_WORK;
                end
            end
            ST_WORK:
            begin
                if (step_done)
                begin
                    state_next = cur_eoe_reg ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (flush_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs: one stack action per cycle, at most one emitted item
    always_comb
    begin
        emit       = 1'b0;
        emit_sym   = cur_sym_reg;
        emit_last  = 1'b0;
        cmd.push   = 1'b0;
        cmd.pop    = 1'b0;
        cmd.din    = cur_sym_reg;
        cnt_next   = cnt_reg;
        err_next   = err_reg;
        step_done  = 1'b0;
        flush_done = 1'b0;
        case (state_reg)
            ST_WORK:
            begin
                if (!is_op(cur_sym_reg))
                begin
                    // operand goes straight out
                    if (out_free)
                    begin
                        emit      = 1'b1;
                        step_done = 1'b1;
                    end
                end
                else if (cur_sym_reg == SYM_LPAREN)
                begin
                    if (stack_full)
                    begin
                        if (err_reg == ERR_NONE)
                        begin
                            err_next = ERR_OVERFLOW;
                        end
                    end
                    else
                    begin
                        cmd.push = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    step_done = 1'b1;
                end
                else if (cur_sym_reg == SYM_RPAREN)
                begin
                    if (!stack_empty && top != SYM_LPAREN)
                    begin
                        if (out_free)
                        begin
                            emit     = 1'b1;
                            emit_sym = top;
                            cmd.pop  = 1'b1;
                            cnt_next = cnt_reg - CNT_W'(1);
                        end
                    end
                    else if (!stack_empty)
                    begin
                        // matching open parenthesis is dropped
                        cmd.pop   = 1'b1;
                        cnt_next  = cnt_reg - CNT_W'(1);
                        step_done = 1'b1;
                    end
                    else
                    begin
                        if (err_reg == ERR_NONE)
                        begin
                            err_next = ERR_UNMATCHED;
                        end
                        step_done = 1'b1;
                    end
                end
                else
                begin
                    if (!stack_empty && prec_of(top) >= prec_of(cur_sym_reg))
                    begin
                        if (out_free)
                        begin
                            emit     = 1'b1;
                            emit_sym = top;
                            cmd.pop  = 1'b1;
                            cnt_next = cnt_reg - CNT_W'(1);
                        end
                    end
                    else
                    begin
                        if (stack_full)
                        begin
                            if (err_reg == ERR_NONE)
                            begin
                                err_next = ERR_OVERFLOW;
                            end
                        end
                        else
                        begin
                            cmd.push = 1'b1;
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                        step_done = 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (!stack_empty)
                    begin
                        emit_sym = top;
                        cmd.pop  = 1'b1;
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                    else
                    begin
                        // terminator carries the status, then the error clears
                        emit_sym   = SYM_NUL;
                        emit_last  = 1'b1;
                        err_next   = ERR_NONE;
                        flush_done = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            err_reg   <= err_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cur_sym_reg <= s_axis_tdata;
            cur_eoe_reg <= s_axis_tlast;
        end
        if (emit)
        begin
            out_sym_reg    <= emit_sym;
            out_last_reg   <= emit_last;
            out_status_reg <= err_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sym_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_status_reg;

    // checks
    `ITP_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(STACK_DEPTH))
    `ITP_ASSERT_NOW(a_pop_nonempty, cmd.pop, !stack_empty && !cmd.push)
    `ITP_ASSERT_NEXT(a_term_clears_err, emit && emit_last, err_reg == ERR_NONE)
    `ITP_ASSERT_NEXT(a_accept_to_work, in_accept, state_reg == ST_WORK)

endmodule
